// File: rtl/execution_slot_tracker_core_defines.svh
// assertion helpers shared by the checker
`ifndef EXECUTION_SLOT_TRACKER_CORE_DEFINES_SVH
`define EXECUTION_SLOT_TRACKER_CORE_DEFINES_SVH
`define EST_ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define EST_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// File: rtl/est_pkg.sv
package est_pkg;
  localparam logic [1:0] REQ_RESERVE  = 2'd0;
  localparam logic [1:0] REQ_SET      = 2'd1;
  localparam logic [1:0] REQ_COMPLETE = 2'd2;
  localparam logic [1:0] REQ_SNAPSHOT = 2'd3;

  localparam logic [1:0] LK_FOUND   = 2'd0;
  localparam logic [1:0] LK_MISSING = 2'd1;
  localparam logic [1:0] LK_EXPIRED = 2'd2;

  localparam logic [1:0] ST_PENDING   = 2'd0;
  localparam logic [1:0] ST_COMPLETED = 2'd1;
  localparam logic [1:0] ST_EXPIRED   = 2'd2;

  localparam int IN_W  = 2 + 32 + 8 + 32 + 8 + 8 + 4 + 16 + 32;  // 142
  localparam int IN_BYTES_W = 144;
  localparam int OUT_W = 1 + 2 + 32 + 2 + 32 + 32 + 3 + 2 + 4 + 16 + 32;  // 158
  localparam int OUT_BYTES_W = 160;

  localparam logic [2:0] REG_RETENTION = 3'd0;
  localparam logic [2:0] REG_NO_HTTP   = 3'd1;

  typedef struct packed {
    logic [31:0] duration;
    logic [15:0] http_code;
    logic [3:0]  done_status;
    logic [7:0]  act_index;
    logic [7:0]  entry_number;
    logic [31:0] exec_id;
    logic [7:0]  actions_wanted;
    logic [31:0] now_time;
    logic [1:0]  req_type;
  } req_t;

  typedef struct packed {
    logic [31:0] entry_duration;
    logic [15:0] entry_http;
    logic [3:0]  entry_status;
    logic [1:0]  entry_action;
    logic [2:0]  entry_total;
    logic [31:0] finished_time;
    logic [31:0] created_time;
    logic [1:0]  exec_state;
    logic [31:0] id_out;
    logic [1:0]  lookup_code;
    logic        ok;
  } res_t;
endpackage

// File: rtl/execution_slot_tracker_core.sv
// Slot tracker for multi-action executions. Each request word is handled by a
// sequencer that walks the slot table one slot per cycle with a single compare
// unit. A reserve scans for a free slot, then checks id candidates against the
// table and restarts the check when a candidate collides, then fills one entry
// at a time. A found snapshot gives one result word per entry. s_tready is low
// while a request is in progress. Results leave through a one-word output
// register.
module execution_slot_tracker_core #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // req_type, now_time, actions_wanted, exec_id, entry_number, act_index,
  // done_status, http_code, duration (lowest first)
  input  logic [est_pkg::IN_BYTES_W-1:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // ok, lookup_code, id_out, exec_state, created_time, finished_time,
  // entry_total, entry_action, entry_status, entry_http, entry_duration
  output logic [est_pkg::OUT_BYTES_W-1:0] m_tdata,
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import est_pkg::*;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW = SW + 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_IDCHK = 3'd2;
  localparam logic [2:0] S_ACT   = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;
  localparam logic [2:0] S_SNAP  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [31:0] retention_time, no_http_code;
  logic [31:0] slot_ids [SLOTS];
  logic [31:0] slot_created [SLOTS];
  logic [31:0] slot_finished [SLOTS];
  logic [2:0]  slot_counts [SLOTS];
  logic [7:0]  slot_action_map [SLOTS];
  logic [15:0] slot_statuses [SLOTS];
  logic [15:0] http_mem [SLOTS*4];
  logic [31:0] dur_mem [SLOTS*4];
  logic [15:0] http_rd;
  logic [31:0] dur_rd;
  logic [31:0] last_issued_id;

  logic [2:0]  state;
  req_t        rq;
  logic [SW:0] idx;
  logic        found;
  logic [SW-1:0] hit;
  logic        avail_ok;
  logic [SW-1:0] avail;
  logic [31:0] cand;
  logic [1:0]  ecnt;
  logic [EW-1:0] mem_wa;
  logic        mem_we;
  logic [15:0] mem_wh;
  logic [31:0] mem_wd;
  logic [EW-1:0] mem_ra;

  res_t        res;
  logic        res_last, load, ob_full;

  // shared per-slot compare unit
  logic [SW-1:0] cur;
  logic [2:0]  cur_n;
  logic        cur_done, cur_exp, cur_match;
  logic [31:0] cur_key;
  assign cur = idx[SW-1:0];
  assign cur_n = (slot_counts[cur] > 3'd4) ? 3'd4 : slot_counts[cur];
  always_comb begin
    cur_done = (cur_n != 3'd0);
    for (int e = 0; e < 4; e++)
      if (3'(e) < cur_n && slot_statuses[cur][e*4 +: 4] == 4'd0) cur_done = 1'b0;
  end
  assign cur_exp = cur_done && ((rq.now_time - slot_finished[cur]) >= retention_time);
  assign cur_key = (state == S_IDCHK) ? cand : rq.exec_id;
  assign cur_match = (cur_key != 32'd0) && (slot_ids[cur] == cur_key);

  // found-slot decode, used after the scan
  logic [2:0]  h_n;
  logic        h_done;
  logic [1:0]  h_first;
  logic        h_any;
  logic [7:0]  act8;
  assign h_n = (slot_counts[hit] > 3'd4) ? 3'd4 : slot_counts[hit];
  assign act8 = rq.act_index;
  always_comb begin
    h_done = (h_n != 3'd0);
    h_any = 1'b0;
    h_first = 2'd0;
    for (int e = 3; e >= 0; e--) begin
      if (3'(e) < h_n && slot_statuses[hit][e*4 +: 4] == 4'd0) h_done = 1'b0;
      if (3'(e) < h_n && {6'd0, slot_action_map[hit][e*2 +: 2]} == act8) begin
        h_any = 1'b1;
        h_first = 2'(e);
      end
    end
  end
  logic [15:0] new_stat;
  logic        new_done;
  always_comb begin
    new_stat = slot_statuses[hit];
    new_stat[h_first*4 +: 4] = rq.done_status;
    new_done = 1'b1;
    for (int e = 0; e < 4; e++)
      if (3'(e) < h_n && new_stat[e*4 +: 4] == 4'd0) new_done = 1'b0;
  end

  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      1'b0:    prdata = retention_time;
      default: prdata = no_http_code;
    endcase
  end

  assign s_tready = (state == S_IDLE);
  // entry 0 is fetched while the action cycle decides on the snapshot
  assign mem_ra = (state == S_ACT) ? {hit, 2'd0} : {hit, ecnt};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      http_mem[mem_wa] <= mem_wh;
      dur_mem[mem_wa] <= mem_wd;
    end
    http_rd <= http_mem[mem_ra];
    dur_rd <= dur_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    load <= 1'b0;
    mem_we <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      retention_time <= 32'd60000;
      no_http_code <= 32'd0;
      last_issued_id <= 32'd0;
      for (int s = 0; s < SLOTS; s++) begin
        slot_ids[s] <= '0; slot_created[s] <= '0; slot_finished[s] <= '0;
        slot_counts[s] <= '0; slot_action_map[s] <= '0; slot_statuses[s] <= '0;
      end
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr == {REG_RETENTION[0], 2'b00}) retention_time <= pwdata;
        else if (paddr == {REG_NO_HTTP[0], 2'b00}) no_http_code <= {16'd0, pwdata[15:0]};
      end
      case (state)
        S_IDLE: if (s_tvalid) begin
          rq <= req_t'(s_tdata[IN_W-1:0]);
          idx <= '0; found <= 1'b0; avail_ok <= 1'b0; hit <= '0; avail <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (rq.req_type == REQ_RESERVE) begin
            if (rq.actions_wanted == 8'd0 || rq.actions_wanted > 8'd4) begin
              res <= '0; res_last <= 1'b1; load <= 1'b1; state <= S_OUT;
            end else begin
              if (slot_ids[cur] != 32'd0 && cur_exp) begin
                slot_ids[cur] <= '0; slot_created[cur] <= '0; slot_finished[cur] <= '0;
                slot_counts[cur] <= '0; slot_action_map[cur] <= '0;
                slot_statuses[cur] <= '0;
              end
              if (!avail_ok && (slot_ids[cur] == 32'd0 || cur_exp)) begin
                avail_ok <= 1'b1; avail <= cur;
              end
              if (idx == (SW+1)'(SLOTS-1)) begin
                if (!avail_ok && !(slot_ids[cur] == 32'd0 || cur_exp)) begin
                  res <= '0; res_last <= 1'b1; load <= 1'b1; state <= S_OUT;
                end else begin
                  cand <= (last_issued_id == 32'hffffffff) ? 32'd1 : last_issued_id + 32'd1;
                  idx <= '0; state <= S_IDCHK;
                end
              end else idx <= idx + 1'b1;
            end
          end else begin
            if (!found && cur_match) begin found <= 1'b1; hit <= cur; end
            if (idx == (SW+1)'(SLOTS-1)) state <= S_ACT;
            else idx <= idx + 1'b1;
          end
        end
        S_IDCHK: begin
          if (cur_match) begin
            cand <= (cand == 32'hffffffff) ? 32'd1 : cand + 32'd1;
            idx <= '0;
          end else if (idx == (SW+1)'(SLOTS-1)) begin
            last_issued_id <= cand;
            slot_ids[avail] <= cand; slot_created[avail] <= rq.now_time;
            slot_finished[avail] <= '0; slot_counts[avail] <= rq.actions_wanted[2:0];
            slot_action_map[avail] <= '0; slot_statuses[avail] <= '0;
            hit <= avail; ecnt <= '0; state <= S_FILL;
          end else idx <= idx + 1'b1;
        end
        S_FILL: begin
          mem_we <= 1'b1; mem_wa <= {hit, ecnt}; mem_wh <= no_http_code[15:0];
          mem_wd <= '0;
          if ({1'b0, ecnt} + 3'd1 == rq.actions_wanted[2:0]) begin
            res <= '0; res.ok <= 1'b1; res.id_out <= cand; res_last <= 1'b1;
            load <= 1'b1; state <= S_OUT;
          end else ecnt <= ecnt + 2'd1;
        end
        S_ACT: begin
          res <= '0; res_last <= 1'b1;
          case (rq.req_type)
            REQ_SET: begin
              if (found && {5'd0, h_n} > rq.entry_number && rq.act_index < 8'd4) begin
                slot_action_map[hit][rq.entry_number[1:0]*2 +: 2] <= rq.act_index[1:0];
                slot_statuses[hit][rq.entry_number[1:0]*4 +: 4] <= 4'd0;
                res.ok <= 1'b1;
              end
              load <= 1'b1; state <= S_OUT;
            end
            REQ_COMPLETE: begin
              if (found && rq.done_status != 4'd0 && h_any &&
                  slot_statuses[hit][h_first*4 +: 4] == 4'd0) begin
                slot_statuses[hit] <= new_stat;
                mem_we <= 1'b1; mem_wa <= {hit, h_first};
                mem_wh <= rq.http_code; mem_wd <= rq.duration;
                if (new_done) slot_finished[hit] <= rq.now_time;
                res.ok <= 1'b1;
              end
              load <= 1'b1; state <= S_OUT;
            end
            default: begin
              if (!found) begin
                res.lookup_code <= LK_MISSING; load <= 1'b1; state <= S_OUT;
              end else if (h_done &&
                           (rq.now_time - slot_finished[hit]) >= retention_time) begin
                slot_ids[hit] <= '0; slot_created[hit] <= '0; slot_finished[hit] <= '0;
                slot_counts[hit] <= '0; slot_action_map[hit] <= '0;
                slot_statuses[hit] <= '0;
                res.lookup_code <= LK_EXPIRED; res.exec_state <= ST_EXPIRED;
                res.id_out <= rq.exec_id; load <= 1'b1; state <= S_OUT;
              end else begin
                ecnt <= '0; state <= S_SNAP;
              end
            end
          endcase
        end
        S_SNAP: if (!ob_full && !load) begin
          // memory read for ecnt was issued last cycle
          res.ok <= 1'b1; res.lookup_code <= LK_FOUND; res.id_out <= rq.exec_id;
          res.exec_state <= h_done ? ST_COMPLETED : ST_PENDING;
          res.created_time <= slot_created[hit];
          res.finished_time <= slot_finished[hit];
          res.entry_total <= slot_counts[hit];
          res.entry_action <= slot_action_map[hit][ecnt*2 +: 2];
          res.entry_status <= slot_statuses[hit][ecnt*4 +: 4];
          res.entry_http <= http_rd; res.entry_duration <= dur_rd;
          res_last <= ({1'b0, ecnt} + 3'd1 >= h_n);
          load <= 1'b1;
          if ({1'b0, ecnt} + 3'd1 >= h_n) state <= S_OUT;
          else ecnt <= ecnt + 2'd1;
        end
        S_OUT: if (!ob_full && !load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  est_out_reg u_out (
    .clk(clk), .rst(rst), .load(load), .res(res), .res_last(res_last),
    .full(ob_full), .tvalid(m_tvalid), .tready(m_tready), .tdata(m_tdata),
    .tlast(m_tlast)
  );
endmodule

// File: rtl/est_out_reg.sv
module est_out_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  est_pkg::res_t                 res,
  input  logic                          res_last,
  output logic                          full,
  output logic                          tvalid,
  input  logic                          tready,
  output logic [est_pkg::OUT_BYTES_W-1:0] tdata,
  output logic                          tlast
);
  import est_pkg::*;
  res_t held;
  logic held_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (tready) begin
      full <= 1'b0;
    end
    if (load) begin
      held <= res;
      held_last <= res_last;
    end
  end

  assign tvalid = full;
  assign tdata  = {{(OUT_BYTES_W-OUT_W){1'b0}}, held};
  assign tlast  = held_last;
endmodule

// File: rtl/est_checker.sv
module est_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic m_tlast,
  input logic [est_pkg::OUT_BYTES_W-1:0] m_tdata,
  input logic pready
);
  `include "execution_slot_tracker_core_defines.svh"
  `EST_ASSERT_IMPL(a_pready, clk, rst, 1'b1, pready)
  `EST_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  `EST_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
  `EST_ASSERT_IMPL(a_pad, clk, rst, m_tvalid, m_tdata[159:158] == 2'b00)
endmodule

bind execution_slot_tracker_core est_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast),
  .m_tdata(m_tdata), .pready(pready)
);

// File: tb/execution_slot_tracker_core_tb.sv
`timescale 1ns / 100ps

module execution_slot_tracker_core_tb;
  import est_pkg::*;

  localparam int NSLOT = 8;
  localparam int NACT = 4;
  localparam int LIMIT = 3000000;
  localparam int SETTLE = 120;

  typedef struct packed {
    res_t r;
    logic last;
  } result_word_t;

  class slot_table_scoreboard;
    logic [31:0] ids [NSLOT];
    logic [31:0] created [NSLOT];
    logic [31:0] finished [NSLOT];
    logic [2:0] counts [NSLOT];
    logic [7:0] amap [NSLOT];
    logic [15:0] stats [NSLOT];
    logic [15:0] http [NSLOT*NACT];
    logic [31:0] dur [NSLOT*NACT];
    logic [31:0] last_id;
    logic [31:0] retention;
    logic [15:0] no_http;
    result_word_t pending_q[$];
    int errors;

    function new();
      for (int s = 0; s < NSLOT; s++) begin
        ids[s] = 0; created[s] = 0; finished[s] = 0;
        counts[s] = 0; amap[s] = 0; stats[s] = 0;
      end
      for (int i = 0; i < NSLOT*NACT; i++) begin
        http[i] = 0; dur[i] = 0;
      end
      last_id = 0;
      retention = 60000;
      no_http = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      if (idx == REG_RETENTION) retention = v;
      else if (idx == REG_NO_HTTP) no_http = v[15:0];
    endfunction

    function int find_slot(logic [31:0] id);
      if (id == 0) return -1;
      for (int s = 0; s < NSLOT; s++) if (ids[s] == id) return s;
      return -1;
    endfunction

    function int entries(int s);
      int n;
      n = counts[s];
      return (n > NACT) ? NACT : n;
    endfunction

    function bit all_done(int s);
      int n;
      n = entries(s);
      if (n == 0) return 0;
      for (int e = 0; e < n; e++) if (stats[s][e*4 +: 4] == 0) return 0;
      return 1;
    endfunction

    function bit is_expired(int s, logic [31:0] now);
      logic [31:0] age;
      age = now - finished[s];
      return all_done(s) && (age >= retention);
    endfunction

    function void clear_slot(int s);
      ids[s] = 0; created[s] = 0; finished[s] = 0;
      counts[s] = 0; amap[s] = 0; stats[s] = 0;
    endfunction

    function void note_request(req_t q);
      result_word_t w;
      int s, avail, n;
      logic [31:0] cand;
      bit hit;
      w = '0;
      w.last = 1;
      case (q.req_type)
        REQ_RESERVE: begin
          if (q.actions_wanted >= 1 && q.actions_wanted <= NACT) begin
            avail = -1;
            for (s = 0; s < NSLOT; s++) begin
              if (ids[s] != 0 && is_expired(s, q.now_time)) clear_slot(s);
              if (ids[s] == 0 && avail < 0) avail = s;
            end
            if (avail >= 0) begin
              cand = last_id;
              do begin
                cand++;
                if (cand == 0) cand++;
              end while (find_slot(cand) >= 0);
              last_id = cand;
              ids[avail] = cand; created[avail] = q.now_time; finished[avail] = 0;
              counts[avail] = q.actions_wanted[2:0]; amap[avail] = 0; stats[avail] = 0;
              for (int e = 0; e < q.actions_wanted; e++) begin
                dur[avail*NACT+e] = 0;
                http[avail*NACT+e] = no_http;
              end
              w.r.ok = 1;
              w.r.id_out = cand;
            end
          end
          pending_q.push_back(w);
        end
        REQ_SET: begin
          s = find_slot(q.exec_id);
          if (s >= 0 && q.entry_number < entries(s) && q.act_index < NACT) begin
            amap[s][q.entry_number[1:0]*2 +: 2] = q.act_index[1:0];
            stats[s][q.entry_number[1:0]*4 +: 4] = 0;
            w.r.ok = 1;
          end
          pending_q.push_back(w);
        end
        REQ_COMPLETE: begin
          s = find_slot(q.exec_id);
          if (s >= 0 && q.done_status != 0) begin
            hit = 0;
            for (int e = 0; e < entries(s) && !hit; e++) begin
              if (amap[s][e*2 +: 2] == q.act_index) begin
                hit = 1;
                if (stats[s][e*4 +: 4] == 0) begin
                  stats[s][e*4 +: 4] = q.done_status;
                  http[s*NACT+e] = q.http_code;
                  dur[s*NACT+e] = q.duration;
                  if (all_done(s)) finished[s] = q.now_time;
                  w.r.ok = 1;
                end
              end
            end
          end
          pending_q.push_back(w);
        end
        default: begin
          s = find_slot(q.exec_id);
          if (s < 0) begin
            w.r.lookup_code = LK_MISSING;
            pending_q.push_back(w);
          end else if (is_expired(s, q.now_time)) begin
            clear_slot(s);
            w.r.lookup_code = LK_EXPIRED;
            w.r.id_out = q.exec_id;
            w.r.exec_state = ST_EXPIRED;
            pending_q.push_back(w);
          end else begin
            n = entries(s);
            for (int e = 0; e < n; e++) begin
              w.r.ok = 1;
              w.r.lookup_code = LK_FOUND;
              w.r.id_out = q.exec_id;
              w.r.exec_state = all_done(s) ? ST_COMPLETED : ST_PENDING;
              w.r.created_time = created[s];
              w.r.finished_time = finished[s];
              w.r.entry_total = counts[s];
              w.r.entry_action = amap[s][e*2 +: 2];
              w.r.entry_status = stats[s][e*4 +: 4];
              w.r.entry_http = http[s*NACT+e];
              w.r.entry_duration = dur[s*NACT+e];
              w.last = (e + 1 == n);
              pending_q.push_back(w);
            end
          end
        end
      endcase
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s mismatch: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(res_t a, logic l);
      result_word_t w;
      if (pending_q.size() == 0) begin
        $error("unexpected result word, id_out %0h", a.id_out);
        errors++;
        return;
      end
      w = pending_q.pop_front();
      cmp("ok", w.r.ok, a.ok);
      cmp("lookup_code", w.r.lookup_code, a.lookup_code);
      cmp("id_out", w.r.id_out, a.id_out);
      cmp("exec_state", w.r.exec_state, a.exec_state);
      cmp("created_time", w.r.created_time, a.created_time);
      cmp("finished_time", w.r.finished_time, a.finished_time);
      cmp("entry_total", w.r.entry_total, a.entry_total);
      cmp("entry_action", w.r.entry_action, a.entry_action);
      cmp("entry_status", w.r.entry_status, a.entry_status);
      cmp("entry_http", w.r.entry_http, a.entry_http);
      cmp("entry_duration", w.r.entry_duration, a.entry_duration);
      cmp("last", w.last, l);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_BYTES_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_BYTES_W-1:0] m_tdata;
  logic m_tlast;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  slot_table_scoreboard tracker = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  bit hold_armed = 0;
  bit hold_used = 0;
  int cycle_count = 0;
  logic [31:0] now_ms = 0;

  execution_slot_tracker_core i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver side, with its own long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (hold_armed && !hold_used) begin
      hold_used <= 1;
      hold_cycles <= 600;
      m_tready <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) tracker.note_request(req_t'(s_tdata[IN_W-1:0]));
    if (!rst && m_tvalid && m_tready) tracker.check_result(res_t'(m_tdata[OUT_W-1:0]), m_tlast);
  end

  task automatic send(req_t r);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {{(IN_BYTES_W-IN_W){1'b0}}, r};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (tracker.pending_q.size() != 0 || !s_tready) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx[0], 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    tracker.write_reg(idx, v);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  function automatic req_t mk(logic [1:0] t, logic [31:0] now, logic [7:0] want,
                              logic [31:0] id, logic [7:0] ent, logic [7:0] act,
                              logic [3:0] st, logic [15:0] hc, logic [31:0] d);
    req_t r;
    r.req_type = t; r.now_time = now; r.actions_wanted = want; r.exec_id = id;
    r.entry_number = ent; r.act_index = act; r.done_status = st;
    r.http_code = hc; r.duration = d;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int s, n;
    r.req_type = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 19) == 0) now_ms = $urandom();
    else now_ms = now_ms + $urandom_range(0, 150);
    r.now_time = now_ms;
    s = $urandom_range(0, NSLOT - 1);
    r.exec_id = ($urandom_range(0, 9) == 0) ? $urandom() : tracker.ids[s];
    n = tracker.entries(s);
    r.actions_wanted = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(1, NACT));
    r.entry_number = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                        : $urandom_range(0, (n > 0) ? n - 1 : 0));
    r.act_index = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 3));
    r.done_status = ($urandom_range(0, 19) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
    r.http_code = 16'($urandom());
    r.duration = $urandom();
    // bias toward completes so executions finish and expire
    if ($urandom_range(0, 9) < 2) r.req_type = REQ_COMPLETE;
    return r;
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset settings
    send(mk(REQ_RESERVE, 32'd100, 8'd0, 0, 0, 0, 0, 0, 0));
    send(mk(REQ_RESERVE, 32'd100, 8'd5, 0, 0, 0, 0, 0, 0));
    send(mk(REQ_RESERVE, 32'd100, 8'd255, 0, 0, 0, 0, 0, 0));
    send(mk(REQ_RESERVE, 32'd110, 8'd1, 0, 0, 0, 0, 0, 0));
    send(mk(REQ_RESERVE, 32'hffff_fff0, 8'd4, 0, 0, 0, 0, 0, 0));
    send(mk(REQ_SET, 32'd120, 0, 32'd2, 8'd3, 8'd3, 0, 0, 0));
    send(mk(REQ_SET, 32'd120, 0, 32'd2, 8'd4, 8'd1, 0, 0, 0));
    send(mk(REQ_SET, 32'd120, 0, 32'd2, 8'd1, 8'd4, 0, 0, 0));
    send(mk(REQ_SET, 32'd120, 0, 32'hffff_ffff, 8'd0, 8'd0, 0, 0, 0));
    send(mk(REQ_COMPLETE, 32'd130, 0, 32'd2, 0, 8'd0, 4'd0, 16'd1, 32'd1));
    send(mk(REQ_COMPLETE, 32'd130, 0, 32'd2, 0, 8'd0, 4'd15, 16'hffff, 32'hffff_ffff));
    send(mk(REQ_COMPLETE, 32'd131, 0, 32'd2, 0, 8'd0, 4'd3, 16'd7, 32'd7));
    send(mk(REQ_COMPLETE, 32'd132, 0, 32'd2, 0, 8'd200, 4'd3, 16'd7, 32'd7));
    send(mk(REQ_SNAPSHOT, 32'd140, 0, 32'd0, 0, 0, 0, 0, 0));
    send(mk(REQ_SNAPSHOT, 32'd140, 0, 32'd2, 0, 0, 0, 0, 0));
    send(mk(REQ_COMPLETE, 32'd150, 0, 32'd1, 0, 8'd0, 4'd1, 16'd200, 32'd42));
    send(mk(REQ_SNAPSHOT, 32'd151, 0, 32'd1, 0, 0, 0, 0, 0));
    // retention passed: expires, then is gone
    send(mk(REQ_SNAPSHOT, 32'd60150, 0, 32'd1, 0, 0, 0, 0, 0));
    send(mk(REQ_SNAPSHOT, 32'd60151, 0, 32'd1, 0, 0, 0, 0, 0));
    // fill the table until reserve fails
    for (int i = 0; i < 8; i++) send(mk(REQ_RESERVE, 32'd200, 8'(1 + i % 4), 0, 0, 0, 0, 0, 0));
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 19; recv_idle_pct = 57;
          reg_write(REG_RETENTION, 32'd0);
          reg_write(REG_NO_HTTP, 32'h0000_ffff);
        end
        1: begin
          send_idle_pct = 57; recv_idle_pct = 19;
          reg_write(REG_RETENTION, 32'd300);
          reg_write(REG_NO_HTTP, 32'h0000_a5a5);
        end
        default: begin
          send_idle_pct = 0; recv_idle_pct = 0;
          reg_write(REG_RETENTION, 32'hffff_ffff);
          reg_write(REG_NO_HTTP, 32'd0);
          hold_armed <= 1;
        end
      endcase
      for (int i = 0; i < 105; i++) send(random_request());
      drain();
    end

    if (tracker.errors == 0 && tracker.pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
